// File: src/frustum_box_cull_macros.svh
// Assertion macros used by the checker file.
`ifndef FRUSTUM_BOX_CULL_MACROS_SVH
`define FRUSTUM_BOX_CULL_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum_box_cull check failed");

// Next-cycle implication, disabled while in reset.
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum_box_cull check failed");

`endif

// File: src/fbc_pkg.sv
// Shared constants, types and helpers for the frustum box cull block.
package fbc_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int NORMAL_BITS_DEF = 16;
    localparam int FIELD_BITS      = 16;
    localparam int NUM_AXES        = 3;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_CORNERS     = 8;
    localparam int CORNER_IDX_W    = $clog2(NUM_CORNERS);
    localparam int PLANE_IDX_W     = $clog2(NUM_PLANES);
    localparam int PLANE_REG_BITS  = 64;
    localparam int FBOX_REG_BITS   = 48;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int MODEL_WORD_BITS = 64;
    localparam int OFFSET_SHIFT    = 15;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_PLANE_0   = CFG_INDEX_BITS'(0);
    localparam cfg_index_t REG_PLANE_5   = CFG_INDEX_BITS'(5);
    localparam cfg_index_t REG_FBOX_MIN  = CFG_INDEX_BITS'(6);
    localparam cfg_index_t REG_FBOX_MAX  = CFG_INDEX_BITS'(7);

    typedef enum logic [1:0] {
        OUT_NO_OVERLAP = 2'd0,
        OUT_CENTER     = 2'd1,
        OUT_CORNER     = 2'd2,
        OUT_NONE       = 2'd3
    } outcome_t;

    // Per-stage control that travels with each item.
    typedef struct packed {
        logic valid;
        logic overlap;
    } stage_ctl_t;

    // Width of the dot-product compare; capped at a 64-bit word.
    function automatic int cmp_width(input int cb, input int nb);
        int wide;
        wide = (cb + nb + 3 > cb + OFFSET_SHIFT + 1) ? cb + nb + 3 : cb + OFFSET_SHIFT + 1;
        return (wide > MODEL_WORD_BITS) ? MODEL_WORD_BITS : wide;
    endfunction

endpackage

// File: src/fbc_if.sv
// Channel interfaces: query box, cull result and configuration write.
interface fbc_box_if import fbc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] box_min_x;
    logic signed [FIELD_BITS-1:0] box_min_y;
    logic signed [FIELD_BITS-1:0] box_min_z;
    logic signed [FIELD_BITS-1:0] box_max_x;
    logic signed [FIELD_BITS-1:0] box_max_y;
    logic signed [FIELD_BITS-1:0] box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface fbc_res_if import fbc_pkg::*; ();
    logic     valid;
    logic     ready;
    logic     in_view;
    outcome_t outcome;

    modport source (output valid, in_view, outcome, input ready);
    modport sink (input valid, in_view, outcome, output ready);
endinterface

interface fbc_cfg_if import fbc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    cfg_index_t               index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/fbc_cfg_regs.sv
// Configuration register file and field unpacking for planes and frustum box.
module fbc_cfg_regs import fbc_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NORMAL_BITS = NORMAL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_valid,
    input  cfg_index_t                    wr_index,
    input  logic [CFG_DATA_BITS-1:0]      wr_data,
    output logic signed [NORMAL_BITS-1:0] normal [NUM_PLANES][NUM_AXES],
    output logic signed [COORD_BITS-1:0]  offset [NUM_PLANES],
    output logic signed [COORD_BITS-1:0]  fbox_lo [NUM_AXES],
    output logic signed [COORD_BITS-1:0]  fbox_hi [NUM_AXES]
);

    localparam int PLANE_EXT_W = NUM_AXES * NORMAL_BITS + COORD_BITS;
    localparam int FBOX_EXT_W  = NUM_AXES * COORD_BITS;

    logic [PLANE_REG_BITS-1:0] plane_reg [NUM_PLANES];
    logic [FBOX_REG_BITS-1:0]  fbox_min_reg;
    logic [FBOX_REG_BITS-1:0]  fbox_max_reg;
    logic [NUM_PLANES-1:0]     plane_we;
    logic                      fbox_min_we;
    logic                      fbox_max_we;
    logic [FBOX_EXT_W-1:0]     fbox_min_ext;
    logic [FBOX_EXT_W-1:0]     fbox_max_ext;

    // Plane indexes start at zero, so the low index bits pick the plane.
    always_comb
    begin
        plane_we    = '0;
        fbox_min_we = 1'b0;
        fbox_max_we = 1'b0;
        if (wr_valid)
        begin
            unique case (wr_index) inside
                [REG_PLANE_0:REG_PLANE_5]: plane_we[wr_index[PLANE_IDX_W-1:0]] = 1'b1;
                REG_FBOX_MIN:              fbox_min_we = 1'b1;
                REG_FBOX_MAX:              fbox_max_we = 1'b1;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_PLANES; k++)
            begin
                plane_reg[k] <= '0;
            end
            fbox_min_reg <= '0;
            fbox_max_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_PLANES; k++)
            begin
                if (plane_we[k])
                begin
                    plane_reg[k] <= PLANE_REG_BITS'(wr_data);
                end
            end
            if (fbox_min_we)
            begin
                fbox_min_reg <= FBOX_REG_BITS'(wr_data);
            end
            if (fbox_max_we)
            begin
                fbox_max_reg <= FBOX_REG_BITS'(wr_data);
            end
        end
    end

    // Fields that run past the stored word read as zero.
    for (genvar k = 0; k < NUM_PLANES; k++)
    begin : g_plane
        logic [PLANE_EXT_W-1:0] ext;
        assign ext = PLANE_EXT_W'(plane_reg[k]);
        for (genvar a = 0; a < NUM_AXES; a++)
        begin : g_axis
            assign normal[k][a] = ext[a*NORMAL_BITS +: NORMAL_BITS];
        end
        assign offset[k] = ext[NUM_AXES*NORMAL_BITS +: COORD_BITS];
    end

    assign fbox_min_ext = FBOX_EXT_W'(fbox_min_reg);
    assign fbox_max_ext = FBOX_EXT_W'(fbox_max_reg);

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_fbox
        assign fbox_lo[a] = fbox_min_ext[a*COORD_BITS +: COORD_BITS];
        assign fbox_hi[a] = fbox_max_ext[a*COORD_BITS +: COORD_BITS];
    end

endmodule

// File: src/fbc_prod.sv
// First stage: box overlap test and per-plane corner-coordinate products.
module fbc_prod import fbc_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NORMAL_BITS = NORMAL_BITS_DEF,
    localparam int PROD_W     = COORD_BITS + NORMAL_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [FIELD_BITS-1:0]  box_lo [NUM_AXES],
    input  logic signed [FIELD_BITS-1:0]  box_hi [NUM_AXES],
    input  logic signed [NORMAL_BITS-1:0] normal [NUM_PLANES][NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  fbox_lo [NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  fbox_hi [NUM_AXES],
    output stage_ctl_t                    out_ctl,
    input  logic                          out_ready,
    output logic signed [PROD_W-1:0]      prod_lo_reg [NUM_PLANES][NUM_AXES],
    output logic signed [PROD_W-1:0]      prod_hi_reg [NUM_PLANES][NUM_AXES]
);

    stage_ctl_t                 ctl_reg;
    stage_ctl_t                 ctl_next;
    logic                       overlap;
    logic signed [COORD_BITS-1:0] lo [NUM_AXES];
    logic signed [COORD_BITS-1:0] hi [NUM_AXES];
    logic signed [COORD_BITS-1:0] mx [NUM_AXES];
    logic signed [COORD_BITS-1:0] mn [NUM_AXES];
    logic signed [PROD_W-1:0]     prod_lo [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]     prod_hi [NUM_PLANES][NUM_AXES];

    always_comb
    begin
        overlap = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lo[a] = COORD_BITS'(box_lo[a]);
            hi[a] = COORD_BITS'(box_hi[a]);
            mx[a] = (fbox_lo[a] <= lo[a]) ? lo[a] : fbox_lo[a];
            mn[a] = (fbox_hi[a] <= hi[a]) ? fbox_hi[a] : hi[a];
            if (!(mx[a] <= mn[a]))
            begin
                overlap = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_PLANES; k++)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                prod_lo[k][a] = PROD_W'(lo[a]) * PROD_W'(normal[k][a]);
                prod_hi[k][a] = PROD_W'(hi[a]) * PROD_W'(normal[k][a]);
            end
        end
    end

    assign in_ready = !ctl_reg.valid || out_ready;

    always_comb
    begin
        ctl_next = ctl_reg;
        if (in_ready)
        begin
            ctl_next.valid   = in_valid;
            ctl_next.overlap = overlap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_lo_reg <= prod_lo;
            prod_hi_reg <= prod_hi;
        end
    end

    assign out_ctl = ctl_reg;

endmodule

// File: src/fbc_sum.sv
// Two stages of plane dot-product sums for the center and all eight corners.
module fbc_sum import fbc_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NORMAL_BITS = NORMAL_BITS_DEF,
    localparam int PROD_W     = COORD_BITS + NORMAL_BITS,
    localparam int CMP_W      = cmp_width(COORD_BITS, NORMAL_BITS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  stage_ctl_t               in_ctl,
    output logic                     in_ready,
    input  logic signed [PROD_W-1:0] prod_lo [NUM_PLANES][NUM_AXES],
    input  logic signed [PROD_W-1:0] prod_hi [NUM_PLANES][NUM_AXES],
    output stage_ctl_t               out_ctl,
    input  logic                     out_ready,
    output logic signed [CMP_W-1:0]  center_reg [NUM_PLANES],
    output logic signed [CMP_W-1:0]  corner_reg [NUM_PLANES][NUM_CORNERS]
);

    localparam int SUM_W     = PROD_W + 1;
    localparam int XY_COMBOS = NUM_CORNERS / 2;

    stage_ctl_t              ctl_a_reg;
    stage_ctl_t              ctl_a_next;
    stage_ctl_t              ctl_b_reg;
    stage_ctl_t              ctl_b_next;
    logic                    ready_a;
    logic                    ready_b;
    logic signed [SUM_W-1:0]  pair [NUM_PLANES][NUM_AXES];
    logic signed [SUM_W-1:0]  xy [NUM_PLANES][XY_COMBOS];
    logic signed [SUM_W-1:0]  pair_reg [NUM_PLANES][NUM_AXES];
    logic signed [SUM_W-1:0]  xy_reg [NUM_PLANES][XY_COMBOS];
    logic signed [PROD_W-1:0] z_lo_reg [NUM_PLANES];
    logic signed [PROD_W-1:0] z_hi_reg [NUM_PLANES];
    logic signed [CMP_W-1:0]  center [NUM_PLANES];
    logic signed [CMP_W-1:0]  corner [NUM_PLANES][NUM_CORNERS];

    // Stage A: center pairs (lo+hi)*n per axis, and the four x/y corner partials.
    always_comb
    begin
        for (int k = 0; k < NUM_PLANES; k++)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                pair[k][a] = SUM_W'(prod_lo[k][a]) + SUM_W'(prod_hi[k][a]);
            end
            for (int m = 0; m < XY_COMBOS; m++)
            begin
                xy[k][m] = SUM_W'(m[0] ? prod_hi[k][0] : prod_lo[k][0])
                         + SUM_W'(m[1] ? prod_hi[k][1] : prod_lo[k][1]);
            end
        end
    end

    // Stage B: the center sits at doubled scale, so the corner sums are shifted left by one.
    always_comb
    begin
        for (int k = 0; k < NUM_PLANES; k++)
        begin
            center[k] = '0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                center[k] = center[k] + CMP_W'(pair_reg[k][a]);
            end
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                corner[k][c] = (CMP_W'(xy_reg[k][c[CORNER_IDX_W-2:0]])
                             + CMP_W'(c[CORNER_IDX_W-1] ? z_hi_reg[k] : z_lo_reg[k])) << 1;
            end
        end
    end

    assign ready_b  = !ctl_b_reg.valid || out_ready;
    assign ready_a  = !ctl_a_reg.valid || ready_b;
    assign in_ready = ready_a;

    always_comb
    begin
        ctl_a_next = ready_a ? in_ctl : ctl_a_reg;
        ctl_b_next = ready_b ? ctl_a_reg : ctl_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid && ready_a)
        begin
            pair_reg <= pair;
            xy_reg   <= xy;
            for (int k = 0; k < NUM_PLANES; k++)
            begin
                z_lo_reg[k] <= prod_lo[k][2];
                z_hi_reg[k] <= prod_hi[k][2];
            end
        end
        if (ctl_a_reg.valid && ready_b)
        begin
            center_reg <= center;
            corner_reg <= corner;
        end
    end

    assign out_ctl = ctl_b_reg;

endmodule

// File: src/fbc_decide.sv
// Last stage: plane compares, inside reduction and the registered result.
module fbc_decide import fbc_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NORMAL_BITS = NORMAL_BITS_DEF,
    localparam int CMP_W      = cmp_width(COORD_BITS, NORMAL_BITS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stage_ctl_t                   in_ctl,
    output logic                         in_ready,
    input  logic signed [CMP_W-1:0]      center [NUM_PLANES],
    input  logic signed [CMP_W-1:0]      corner [NUM_PLANES][NUM_CORNERS],
    input  logic signed [COORD_BITS-1:0] offset [NUM_PLANES],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         in_view,
    output outcome_t                     outcome
);

    logic                    valid_reg;
    logic                    valid_next;
    logic                    in_view_reg;
    outcome_t                outcome_reg;
    outcome_t                outcome_next;
    logic signed [CMP_W-1:0] off_s [NUM_PLANES];
    logic                    center_in;
    logic [NUM_CORNERS-1:0]  corner_in;

    always_comb
    begin
        center_in = 1'b1;
        corner_in = '1;
        for (int k = 0; k < NUM_PLANES; k++)
        begin
            off_s[k] = CMP_W'(offset[k]) << OFFSET_SHIFT;
            if (!(center[k] >= off_s[k]))
            begin
                center_in = 1'b0;
            end
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                if (!(corner[k][c] >= off_s[k]))
                begin
                    corner_in[c] = 1'b0;
                end
            end
        end

        if (!in_ctl.overlap)
        begin
            outcome_next = OUT_NO_OVERLAP;
        end
        else if (center_in)
        begin
            outcome_next = OUT_CENTER;
        end
        else if (|corner_in)
        begin
            outcome_next = OUT_CORNER;
        end
        else
        begin
            outcome_next = OUT_NONE;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_ctl.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid && in_ready)
        begin
            outcome_reg <= outcome_next;
            in_view_reg <= (outcome_next == OUT_CENTER) || (outcome_next == OUT_CORNER);
        end
    end

    assign out_valid = valid_reg;
    assign in_view   = in_view_reg;
    assign outcome   = outcome_reg;

endmodule

// File: src/frustum_box_cull.sv
// Frustum box cull: four-stage pipeline, overlap + center + corner tests.
// Each item passes through one register per stage
// (products, pair sums, plane sums, compare and output register).
// Throughput: one item per cycle unless res.ready stalls; 36 plane products in parallel.
// Reset: rst_n clears all valid bits and the plane and frustum box registers to zero.
module frustum_box_cull import fbc_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int NORMAL_BITS = NORMAL_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    fbc_box_if.sink   box,
    fbc_res_if.source res,
    fbc_cfg_if.sink   cfg
);

    localparam int PROD_W = COORD_BITS + NORMAL_BITS;
    localparam int CMP_W  = cmp_width(COORD_BITS, NORMAL_BITS);

    logic signed [NORMAL_BITS-1:0] normal [NUM_PLANES][NUM_AXES];
    logic signed [COORD_BITS-1:0]  offset [NUM_PLANES];
    logic signed [COORD_BITS-1:0]  fbox_lo [NUM_AXES];
    logic signed [COORD_BITS-1:0]  fbox_hi [NUM_AXES];
    logic signed [FIELD_BITS-1:0]  box_lo [NUM_AXES];
    logic signed [FIELD_BITS-1:0]  box_hi [NUM_AXES];
    logic signed [PROD_W-1:0]      prod_lo [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0]      prod_hi [NUM_PLANES][NUM_AXES];
    logic signed [CMP_W-1:0]       center [NUM_PLANES];
    logic signed [CMP_W-1:0]       corner [NUM_PLANES][NUM_CORNERS];
    stage_ctl_t                    prod_ctl;
    stage_ctl_t                    sum_ctl;
    logic                          sum_ready;
    logic                          decide_ready;

    assign cfg.ready = 1'b1;

    assign box_lo[0] = box.box_min_x;
    assign box_lo[1] = box.box_min_y;
    assign box_lo[2] = box.box_min_z;
    assign box_hi[0] = box.box_max_x;
    assign box_hi[1] = box.box_max_y;
    assign box_hi[2] = box.box_max_z;

    fbc_cfg_regs #(
        .COORD_BITS  (COORD_BITS),
        .NORMAL_BITS (NORMAL_BITS)
    ) u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .normal   (normal),
        .offset   (offset),
        .fbox_lo  (fbox_lo),
        .fbox_hi  (fbox_hi)
    );

    fbc_prod #(
        .COORD_BITS  (COORD_BITS),
        .NORMAL_BITS (NORMAL_BITS)
    ) u_prod (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (box.valid),
        .in_ready    (box.ready),
        .box_lo      (box_lo),
        .box_hi      (box_hi),
        .normal      (normal),
        .fbox_lo     (fbox_lo),
        .fbox_hi     (fbox_hi),
        .out_ctl     (prod_ctl),
        .out_ready   (sum_ready),
        .prod_lo_reg (prod_lo),
        .prod_hi_reg (prod_hi)
    );

    fbc_sum #(
        .COORD_BITS  (COORD_BITS),
        .NORMAL_BITS (NORMAL_BITS)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (prod_ctl),
        .in_ready   (sum_ready),
        .prod_lo    (prod_lo),
        .prod_hi    (prod_hi),
        .out_ctl    (sum_ctl),
        .out_ready  (decide_ready),
        .center_reg (center),
        .corner_reg (corner)
    );

    fbc_decide #(
        .COORD_BITS  (COORD_BITS),
        .NORMAL_BITS (NORMAL_BITS)
    ) u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (sum_ctl),
        .in_ready  (decide_ready),
        .center    (center),
        .corner    (corner),
        .offset    (offset),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .in_view   (res.in_view),
        .outcome   (res.outcome)
    );

endmodule

// File: src/fbc_checker.sv
// Port-level checks for frustum_box_cull, bound to the top level.
`include "frustum_box_cull_macros.svh"

module fbc_checker import fbc_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     box_valid,
    input logic     box_ready,
    input logic     res_valid,
    input logic     res_ready,
    input logic     res_in_view,
    input outcome_t res_outcome
);

    // A waiting result stays offered and unchanged.
    `FBC_ASSERT_NEXT(a_res_valid_holds, clk, rst_n, res_valid && !res_ready, res_valid)
    `FBC_ASSERT_NEXT(a_res_payload_holds, clk, rst_n, res_valid && !res_ready, $stable(res_outcome) && $stable(res_in_view))

    // With nothing waiting at the output, no stage can be holding back the input.
    `FBC_ASSERT_IMPL(a_ready_when_drained, clk, rst_n, !res_valid, box_ready)

    // in_view is set exactly for center or corner hits.
    `FBC_ASSERT_IMPL(a_in_view_matches, clk, rst_n, res_valid, res_in_view == ((res_outcome == OUT_CENTER) || (res_outcome == OUT_CORNER)))

    // box_valid is watched only to keep the item handshake visible in waves.
    logic box_accept;
    assign box_accept = box_valid && box_ready;
    `FBC_ASSERT_IMPL(a_accept_needs_ready, clk, rst_n, box_accept, box_ready)

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .box_valid   (box.valid),
    .box_ready   (box.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_in_view (res.in_view),
    .res_outcome (res.outcome)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for frustum_box_cull: directed boxes, back-pressure, random scenes, streaming.
module tb_top;
    import fbc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int Q14_ONE      = 16384;
    localparam int COORD_MIN    = -32768;
    localparam int COORD_MAX    = 32767;
    localparam int SCENE_BOXES  = 60;

    typedef struct packed {
        logic [2:0][FIELD_BITS-1:0] lo;
        logic [2:0][FIELD_BITS-1:0] hi;
    } box_t;

    typedef struct packed {
        logic     in_view;
        outcome_t outcome;
    } verdict_t;

    logic clk;
    logic rst_n;

    fbc_box_if box_ch ();
    fbc_res_if res_ch ();
    fbc_cfg_if cfg_ch ();

    frustum_box_cull i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .box   (box_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // shadow copy of the configuration registers
    logic [PLANE_REG_BITS-1:0] plane_shadow [NUM_PLANES];
    logic [FBOX_REG_BITS-1:0]  fbox_min_shadow;
    logic [FBOX_REG_BITS-1:0]  fbox_max_shadow;

    // scene staged for the next register load
    logic [PLANE_REG_BITS-1:0] scene_planes [NUM_PLANES];
    logic [FBOX_REG_BITS-1:0]  scene_fmin;
    logic [FBOX_REG_BITS-1:0]  scene_fmax;
    int                        scene_c [3];
    int                        scene_h [3];

    verdict_t pending_verdicts [$];
    int       errors = 0;
    int       boxes_checked = 0;
    int       outcome_seen [4] = '{0, 0, 0, 0};
    int       scene_loads = 0;
    bit       tx_idle_on = 1'b1;
    bit       rx_idle_on = 1'b1;
    int       sink_hold_cycles = 0;
    int       longest_hold = 0;
    int       cycle_count = 0;

    function automatic longint sx(input logic [FIELD_BITS-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    function automatic logic [PLANE_REG_BITS-1:0] pack_plane(input int nx, input int ny,
                                                             input int nz, input int off);
        return {FIELD_BITS'(off), FIELD_BITS'(nz), FIELD_BITS'(ny), FIELD_BITS'(nx)};
    endfunction

    function automatic logic [FBOX_REG_BITS-1:0] pack_coords(input int x, input int y,
                                                             input int z);
        return {FIELD_BITS'(z), FIELD_BITS'(y), FIELD_BITS'(x)};
    endfunction

    function automatic box_t make_box(input int x0, input int y0, input int z0,
                                      input int x1, input int y1, input int z1);
        box_t b;
        b.lo[0] = FIELD_BITS'(x0);
        b.lo[1] = FIELD_BITS'(y0);
        b.lo[2] = FIELD_BITS'(z0);
        b.hi[0] = FIELD_BITS'(x1);
        b.hi[1] = FIELD_BITS'(y1);
        b.hi[2] = FIELD_BITS'(z1);
        return b;
    endfunction

    // points are at doubled scale, so the bound is offset * 2^15
    function automatic bit point_in_frustum(input longint px, input longint py,
                                            input longint pz);
        logic [PLANE_REG_BITS-1:0] pl;
        longint                    dot;
        longint                    bound;
        int                        k;
        for (k = 0; k < NUM_PLANES; k++) begin
            pl    = plane_shadow[k];
            dot   = px * sx(pl[0 +: FIELD_BITS]) + py * sx(pl[FIELD_BITS +: FIELD_BITS])
                  + pz * sx(pl[2*FIELD_BITS +: FIELD_BITS]);
            bound = sx(pl[3*FIELD_BITS +: FIELD_BITS]) * (longint'(1) << OFFSET_SHIFT);
            if (dot < bound) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t cull_verdict(input box_t b);
        longint   lo [3];
        longint   hi [3];
        longint   fmn;
        longint   fmx;
        longint   mx;
        longint   mn;
        bit       overlap;
        int       a;
        int       c;
        verdict_t v;
        overlap = 1'b1;
        for (a = 0; a < 3; a++) begin
            lo[a] = sx(b.lo[a]);
            hi[a] = sx(b.hi[a]);
            fmn   = sx(fbox_min_shadow[a*FIELD_BITS +: FIELD_BITS]);
            fmx   = sx(fbox_max_shadow[a*FIELD_BITS +: FIELD_BITS]);
            mx    = (fmn > lo[a]) ? fmn : lo[a];
            mn    = (fmx < hi[a]) ? fmx : hi[a];
            if (mx > mn) overlap = 1'b0;
        end
        v.outcome = OUT_NONE;
        if (!overlap)
            v.outcome = OUT_NO_OVERLAP;
        else if (point_in_frustum(lo[0] + hi[0], lo[1] + hi[1], lo[2] + hi[2]))
            v.outcome = OUT_CENTER;
        else
            for (c = 0; c < NUM_CORNERS; c++)
                if (v.outcome == OUT_NONE &&
                    point_in_frustum(c[0] ? 2 * hi[0] : 2 * lo[0],
                                     c[1] ? 2 * hi[1] : 2 * lo[1],
                                     c[2] ? 2 * hi[2] : 2 * lo[2]))
                    v.outcome = OUT_CORNER;
        v.in_view = (v.outcome == OUT_CENTER || v.outcome == OUT_CORNER);
        return v;
    endfunction

    // mostly boxes scattered around the scene, some raw noise, a few inverted
    function automatic box_t scene_box();
        box_t b;
        int   a;
        int   q;
        int   half;
        int   lo;
        int   hi;
        int   t;
        if ($urandom_range(0, 99) < 15) begin
            b = {$urandom, $urandom, $urandom};
            return b;
        end
        for (a = 0; a < 3; a++) begin
            q    = scene_c[a] + int'($urandom_range(0, 4 * scene_h[a])) - 2 * scene_h[a];
            half = $urandom_range(0, scene_h[a]);
            lo   = clamp_coord(q - half);
            hi   = clamp_coord(q + half);
            if ($urandom_range(0, 29) == 0) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            b.lo[a] = FIELD_BITS'(lo);
            b.hi[a] = FIELD_BITS'(hi);
        end
        return b;
    endfunction

    // tilted slab: a pair of facing planes per axis around a random center
    task automatic build_slab_scene();
        int a;
        int m;
        int margin;
        int n [3];
        int fmn [3];
        int fmx [3];
        for (a = 0; a < 3; a++) begin
            scene_c[a] = int'($urandom_range(0, 16000)) - 8000;
            scene_h[a] = $urandom_range(64, 6000);
        end
        for (a = 0; a < 3; a++) begin
            m = $urandom_range(4096, 32767);
            n[a] = m;
            n[(a + 1) % 3] = int'($urandom_range(0, 6000)) - 3000;
            n[(a + 2) % 3] = int'($urandom_range(0, 6000)) - 3000;
            scene_planes[2*a] = pack_plane(n[0], n[1], n[2],
                                           (scene_c[a] - scene_h[a]) * m / Q14_ONE);
            m = $urandom_range(4096, 32767);
            n[a] = -m;
            n[(a + 1) % 3] = int'($urandom_range(0, 6000)) - 3000;
            n[(a + 2) % 3] = int'($urandom_range(0, 6000)) - 3000;
            scene_planes[2*a+1] = pack_plane(n[0], n[1], n[2],
                                             -((scene_c[a] + scene_h[a]) * m / Q14_ONE));
            margin = int'($urandom_range(0, scene_h[a])) - scene_h[a] / 2;
            fmn[a] = clamp_coord(scene_c[a] - scene_h[a] - margin);
            fmx[a] = clamp_coord(scene_c[a] + scene_h[a] + margin);
        end
        scene_fmin = pack_coords(fmn[0], fmn[1], fmn[2]);
        scene_fmax = pack_coords(fmx[0], fmx[1], fmx[2]);
    endtask

    task automatic build_noise_scene();
        int a;
        for (a = 0; a < NUM_PLANES; a++)
            scene_planes[a] = {$urandom, $urandom};
        for (a = 0; a < 3; a++) begin
            scene_c[a] = 0;
            scene_h[a] = 16000;
        end
        if ($urandom_range(0, 1) == 0) begin
            scene_fmin = pack_coords(COORD_MIN, COORD_MIN, COORD_MIN);
            scene_fmax = pack_coords(COORD_MAX, COORD_MAX, COORD_MAX);
        end
        else begin
            scene_fmin = FBOX_REG_BITS'({$urandom, $urandom});
            scene_fmax = FBOX_REG_BITS'({$urandom, $urandom});
        end
    endtask

    task automatic send_box(input box_t b);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge clk);
        if (gap > 0) begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        box_ch.valid     <= 1'b1;
        box_ch.box_min_x <= b.lo[0];
        box_ch.box_min_y <= b.lo[1];
        box_ch.box_min_z <= b.lo[2];
        box_ch.box_max_x <= b.hi[0];
        box_ch.box_max_y <= b.hi[1];
        box_ch.box_max_z <= b.hi[2];
        do @(posedge clk); while (!box_ch.ready);
        pending_verdicts.push_back(cull_verdict(b));
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        // out-of-range indexes fall through and change nothing
        if (idx <= REG_PLANE_5)
            plane_shadow[idx - REG_PLANE_0] = data;
        else if (idx == REG_FBOX_MIN)
            fbox_min_shadow = data[FBOX_REG_BITS-1:0];
        else if (idx == REG_FBOX_MAX)
            fbox_max_shadow = data[FBOX_REG_BITS-1:0];
    endtask

    task automatic release_cfg();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        box_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic load_scene();
        logic [CFG_DATA_BITS-1:0] junk;
        int                       k;
        drain_pipeline();
        for (k = 0; k < NUM_PLANES; k++)
            write_reg(cfg_index_t'(REG_PLANE_0 + k), scene_planes[k]);
        // upper data bits above the box fields must be dropped
        junk = {$urandom, $urandom};
        write_reg(REG_FBOX_MIN, {junk[CFG_DATA_BITS-1:FBOX_REG_BITS], scene_fmin});
        junk = {$urandom, $urandom};
        write_reg(REG_FBOX_MAX, {junk[CFG_DATA_BITS-1:FBOX_REG_BITS], scene_fmax});
        if ($urandom_range(0, 2) == 0)
            write_reg(cfg_index_t'($urandom_range(REG_FBOX_MAX + 1, 2**CFG_INDEX_BITS - 1)),
                      {$urandom, $urandom});
        release_cfg();
        scene_loads++;
    endtask

    // registers at their reset values: zero normals, zero offsets, point box at origin
    task automatic test_reset_state();
        send_box(make_box(-5, -5, -5, 5, 5, 5));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(1, -5, -5, 5, 5, 5));
        send_box(make_box(-10, -10, -10, -1, -1, -1));
    endtask

    task automatic test_directed_cases();
        int a;
        // axis-aligned cube of half size 1000, frustum box a little wider
        for (a = 0; a < 3; a++) begin
            scene_planes[2*a]   = pack_plane(a == 0 ? Q14_ONE : 0, a == 1 ? Q14_ONE : 0,
                                             a == 2 ? Q14_ONE : 0, -1000);
            scene_planes[2*a+1] = pack_plane(a == 0 ? -Q14_ONE : 0, a == 1 ? -Q14_ONE : 0,
                                             a == 2 ? -Q14_ONE : 0, -1000);
        end
        scene_fmin = pack_coords(-1500, -1500, -1500);
        scene_fmax = pack_coords(1500, 1500, 1500);
        load_scene();
        send_box(make_box(-10, -10, -10, 10, 10, 10));
        send_box(make_box(900, -10, -10, 1500, 10, 10));      // only a corner inside
        send_box(make_box(1100, -10, -10, 1400, 10, 10));     // overlaps, nothing inside
        send_box(make_box(1500, -10, -10, 2000, 10, 10));     // touches the frustum box
        send_box(make_box(-2000, 0, 0, -1501, 0, 0));         // just misses it
        send_box(make_box(10, -10, -10, -10, 10, 10));        // inverted on x
        send_box(make_box(-10, 10, -10, 10, -10, 10));        // inverted on y
        send_box(make_box(-10, -10, 10, 10, 10, -10));        // inverted on z
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));

        // writes past the last register are ignored
        drain_pipeline();
        write_reg(cfg_index_t'(REG_FBOX_MAX + 1), '0);
        write_reg(cfg_index_t'('1), '1);
        release_cfg();
        send_box(make_box(900, -10, -10, 1500, 10, 10));

        // most negative normals and offsets, widest frustum box
        for (a = 0; a < NUM_PLANES; a++)
            scene_planes[a] = pack_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        scene_fmin = pack_coords(COORD_MIN, COORD_MIN, COORD_MIN);
        scene_fmax = pack_coords(COORD_MAX, COORD_MAX, COORD_MAX);
        load_scene();
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));

        // most positive normals and offsets
        for (a = 0; a < NUM_PLANES; a++)
            scene_planes[a] = pack_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        load_scene();
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(make_box(COORD_MIN, 0, 0, COORD_MAX, 100, 100));

        // zero normals, one plane with a positive offset; frustum box inverted on x
        for (a = 0; a < NUM_PLANES; a++)
            scene_planes[a] = '0;
        scene_planes[3] = pack_plane(0, 0, 0, 1);
        scene_fmin = pack_coords(100, COORD_MIN, COORD_MIN);
        scene_fmax = pack_coords(-100, COORD_MAX, COORD_MAX);
        load_scene();
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        scene_fmin = pack_coords(COORD_MIN, COORD_MIN, COORD_MIN);
        scene_fmax = pack_coords(COORD_MAX, COORD_MAX, COORD_MAX);
        load_scene();
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    endtask

    // sink holds off while the source keeps offering, so the pipeline backs up
    task automatic test_backpressure();
        int n;
        build_slab_scene();
        load_scene();
        tx_idle_on       = 1'b0;
        rx_idle_on       = 1'b0;
        sink_hold_cycles = 200;
        longest_hold     = 200;
        for (n = 0; n < SCENE_BOXES; n++)
            send_box(scene_box());
        drain_pipeline();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_scenes();
        int phase;
        int n;
        for (phase = 0; phase < 9; phase++) begin
            if (phase % 4 == 3)
                build_noise_scene();
            else
                build_slab_scene();
            load_scene();
            for (n = 0; n < SCENE_BOXES; n++)
                send_box(scene_box());
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_streaming();
        int phase;
        int n;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (phase = 0; phase < 2; phase++) begin
            build_slab_scene();
            load_scene();
            for (n = 0; n < SCENE_BOXES; n++)
                send_box(scene_box());
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin : cycle_watchdog
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t: timeout after %0d cycles, %0d items outstanding",
                         $time, cycle_count, pending_verdicts.size());
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                sink_hold_cycles--;
            end
            else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        verdict_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with no item pending, actual in_view %0d outcome %0d",
                         $time, res_ch.in_view, res_ch.outcome);
                errors++;
            end
            else begin
                want = pending_verdicts.pop_front();
                boxes_checked++;
                outcome_seen[int'(res_ch.outcome)]++;
                if (res_ch.in_view !== want.in_view) begin
                    $display("%0t: in_view mismatch, expected %0d actual %0d",
                             $time, want.in_view, res_ch.in_view);
                    errors++;
                end
                if (res_ch.outcome !== want.outcome) begin
                    $display("%0t: outcome mismatch, expected %0d actual %0d",
                             $time, want.outcome, res_ch.outcome);
                    errors++;
                end
            end
        end
    end

    initial begin : test_sequence
        int k;
        rst_n            = 1'b0;
        box_ch.valid     = 1'b0;
        box_ch.box_min_x = '0;
        box_ch.box_min_y = '0;
        box_ch.box_min_z = '0;
        box_ch.box_max_x = '0;
        box_ch.box_max_y = '0;
        box_ch.box_max_z = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_PLANE_0;
        cfg_ch.data      = '0;
        for (k = 0; k < NUM_PLANES; k++)
            plane_shadow[k] = '0;
        fbox_min_shadow = '0;
        fbox_max_shadow = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_directed_cases();
        test_backpressure();
        test_random_scenes();
        test_streaming();
        drain_pipeline();

        $display("tb_top: %0d boxes checked: %0d no overlap, %0d center, %0d corner, %0d none",
                 boxes_checked, outcome_seen[0], outcome_seen[1], outcome_seen[2],
                 outcome_seen[3]);
        $display("tb_top: %0d frustum settings loaded, sink held off for %0d cycles once",
                 scene_loads, longest_hold);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
